// File: hdl/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the i2c master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // field widths
   localparam int LEN_W        = 5;
   localparam int ADDR7_W      = 7;
   localparam int BYTE_W       = 8;
   localparam int RX_INDEX_W   = 4;
   localparam int DEFAULT_MAX_BYTES = 16;

   // item operations
   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_START_RD = 2'd1,
      OP_START_WR = 2'd2,
      OP_EVENT    = 2'd3
   } op_type;

   // bus commands
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_CONT  = 3'd2,
      CMD_ACK   = 3'd3,
      CMD_NACK  = 3'd4,
      CMD_STOP  = 3'd5
   } cmd_type;

   // bus status codes, already masked
   localparam logic [7:0] STATUS_MASK   = 8'hF8;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_REP_START  = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
   localparam logic [7:0] ST_DAT_W_ACK  = 8'h28;
   localparam logic [7:0] ST_DAT_W_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST   = 8'h38;
   localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
   localparam logic [7:0] ST_DAT_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DAT_R_NACK = 8'h58;

   // one result transaction
   typedef struct packed {
      cmd_type                 command;
      logic [BYTE_W-1:0]       tx_byte;
      logic                    rx_valid;
      logic [BYTE_W-1:0]       rx_byte;
      logic [RX_INDEX_W-1:0]   rx_index;
      logic                    done_res;
      logic                    failed;
   } rsp_type;

endpackage : i2cm_pkg
`default_nettype wire

// File: hdl/i2cm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_req_if
// Request channel: buffer loads, transaction starts and bus status events.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       operation;
   logic [i2cm_pkg::ADDR7_W-1:0]     slave_address;
   logic [i2cm_pkg::LEN_W-1:0]       length;
   logic [7:0]                       status_code;
   logic [i2cm_pkg::BYTE_W-1:0]      bus_rx_byte;
   logic [i2cm_pkg::BYTE_W-1:0]      write_byte;

   modport source (
      output valid, operation, slave_address, length, status_code, bus_rx_byte,
             write_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, slave_address, length, status_code, bus_rx_byte,
             write_byte,
      output ready
   );
endinterface : i2cm_req_if

// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Response channel: bus command, read data and completion flags.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       command;
   logic [i2cm_pkg::BYTE_W-1:0]      tx_byte;
   logic                             rx_valid;
   logic [i2cm_pkg::BYTE_W-1:0]      rx_byte;
   logic [i2cm_pkg::RX_INDEX_W-1:0]  rx_index;
   logic                             done_res;
   logic                             failed;

   modport source (
      output valid, command, tx_byte, rx_valid, rx_byte, rx_index, done_res, failed,
      input  ready
   );
   modport sink (
      input  valid, command, tx_byte, rx_valid, rx_byte, rx_index, done_res, failed,
      output ready
   );
endinterface : i2cm_rsp_if
`default_nettype wire

// File: hdl/i2cm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : i2cm_ram
`default_nettype wire

// File: hdl/i2c_master_transaction_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transaction_fsm
// Status-driven i2c master sequencer: write buffer, start, bus events.
//
//   channel   dir   carries
//   req_chan  in    load / start read / start write / bus status event
//   rsp_chan  out   command, tx byte, read byte and index, done, failed
//
// One transaction is accepted per cycle unless the response stalls; the
// response passes the middle stage (accept, buffer read) and then the output
// register. The write buffer RAM read is registered; scalar state updates at
// accept. Reset is synchronous and clears busy and the pipeline; buffer is
// undefined. A stalled response holds the middle stage, then the request side.
// ----------------------------------------------------------------------------
module i2c_master_transaction_fsm #(
   parameter int MAX_BYTES = i2cm_pkg::DEFAULT_MAX_BYTES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   i2cm_req_if.sink    req_chan,
   i2cm_rsp_if.source  rsp_chan
);
   import i2cm_pkg::*;

   localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W  = ($clog2(MAX_BYTES + 1) > LEN_W) ? $clog2(MAX_BYTES + 1)
                                                           : LEN_W;

   // scalar state
   logic [BYTE_W-1:0] address_byte_ff, address_byte_in;
   logic [LEN_W-1:0]  total_length_ff, total_length_in;
   logic [LEN_W-1:0]  byte_index_ff,   byte_index_in;
   logic              busy_ff,         busy_in;

   // pipeline
   logic    s1_valid_ff, s1_valid_in;
   rsp_type s1_rsp_ff,   s1_rsp_in;
   logic    s1_use_ram_ff, s1_use_ram_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff,   out_rsp_in;

   // handshake
   logic req_fire;
   logic out_free;
   logic s1_free;

   // buffer access
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // decode helpers
   op_type            op;
   logic [7:0]        code;
   logic [CNT_W-1:0]  len_ext;
   logic [CNT_W-1:0]  idx_ext;
   logic [LEN_W-1:0]  sat_len;
   logic [LEN_W:0]    ack_idx;
   logic              idx_below;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign req_chan.ready = s1_free;
   assign req_fire = req_chan.valid && s1_free;

   assign op      = op_type'(req_chan.operation);
   assign code    = req_chan.status_code & STATUS_MASK;
   assign len_ext = CNT_W'(req_chan.length);
   assign idx_ext = CNT_W'(byte_index_ff);
   assign idx_below = byte_index_ff < total_length_ff;
   assign sat_len = (len_ext > CNT_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : req_chan.length;

   // buffer write on load, read at the current byte index on every accept
   assign ram_wr_en   = req_fire && (op == OP_LOAD) && (len_ext < CNT_W'(MAX_BYTES));
   assign ram_wr_addr = len_ext[ADDR_W-1:0];
   assign ram_rd_en   = req_fire;
   assign ram_rd_addr = idx_ext[ADDR_W-1:0];

   i2cm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_BYTES)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_chan.write_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // transaction step: next state and response
   always_comb begin
      address_byte_in = address_byte_ff;
      total_length_in = total_length_ff;
      byte_index_in   = byte_index_ff;
      busy_in         = busy_ff;
      s1_rsp_in       = '0;
      s1_use_ram_in   = 1'b0;
      ack_idx         = {1'b0, byte_index_ff} + 1'b1;

      case (op)
         OP_LOAD: begin
         end
         OP_START_RD, OP_START_WR: begin
            address_byte_in = {req_chan.slave_address, (op == OP_START_RD)};
            total_length_in = ((op == OP_START_RD) && (sat_len == '0)) ? LEN_W'(1)
                                                                       : sat_len;
            byte_index_in   = '0;
            busy_in         = 1'b1;
            s1_rsp_in.command = CMD_START;
         end
         OP_EVENT: begin
            if (busy_ff) begin
               case (code)
                  ST_START, ST_REP_START: begin
                     s1_rsp_in.command = CMD_CONT;
                     s1_rsp_in.tx_byte = address_byte_ff;
                  end
                  ST_ARB_LOST: begin
                     s1_rsp_in.done_res = 1'b1;
                     s1_rsp_in.failed   = 1'b1;
                     busy_in            = 1'b0;
                  end
                  ST_SLA_W_ACK, ST_DAT_W_ACK: begin
                     if (idx_below && (idx_ext < CNT_W'(MAX_BYTES))) begin
                        s1_rsp_in.command = CMD_CONT;
                        s1_use_ram_in     = 1'b1;
                        byte_index_in     = byte_index_ff + 1'b1;
                     end else begin
                        s1_rsp_in.command  = CMD_STOP;
                        s1_rsp_in.done_res = 1'b1;
                        busy_in            = 1'b0;
                     end
                  end
                  ST_SLA_W_NACK, ST_DAT_W_NACK, ST_SLA_R_NACK: begin
                     s1_rsp_in.command  = CMD_STOP;
                     s1_rsp_in.done_res = 1'b1;
                     s1_rsp_in.failed   = 1'b1;
                     busy_in            = 1'b0;
                  end
                  ST_SLA_R_ACK: begin
                     s1_rsp_in.command = (ack_idx < {1'b0, total_length_ff}) ? CMD_ACK
                                                                             : CMD_NACK;
                  end
                  ST_DAT_R_ACK: begin
                     // index after taking the byte decides ack or nack
                     if (idx_below) begin
                        s1_rsp_in.rx_valid = 1'b1;
                        s1_rsp_in.rx_byte  = req_chan.bus_rx_byte;
                        s1_rsp_in.rx_index = byte_index_ff[RX_INDEX_W-1:0];
                        byte_index_in      = byte_index_ff + 1'b1;
                        ack_idx            = {1'b0, byte_index_ff} + (LEN_W + 1)'(2);
                     end
                     s1_rsp_in.command = (ack_idx < {1'b0, total_length_ff}) ? CMD_ACK
                                                                             : CMD_NACK;
                  end
                  ST_DAT_R_NACK: begin
                     if (idx_below) begin
                        s1_rsp_in.rx_valid = 1'b1;
                        s1_rsp_in.rx_byte  = req_chan.bus_rx_byte;
                        s1_rsp_in.rx_index = byte_index_ff[RX_INDEX_W-1:0];
                        byte_index_in      = byte_index_ff + 1'b1;
                     end
                     s1_rsp_in.command  = CMD_STOP;
                     s1_rsp_in.done_res = 1'b1;
                     busy_in            = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // pipeline control
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = s1_rsp_ff;
      if (s1_use_ram_ff) begin
         out_rsp_in.tx_byte = ram_rd_data;
      end
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         address_byte_ff <= '0;
         total_length_ff <= '0;
         byte_index_ff   <= '0;
         busy_ff         <= 1'b0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            address_byte_ff <= address_byte_in;
            total_length_ff <= total_length_in;
            byte_index_ff   <= byte_index_in;
            busy_ff         <= busy_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_rsp_ff     <= s1_rsp_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
      if (out_free && s1_valid_ff) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   // response port
   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.command  = out_rsp_ff.command;
   assign rsp_chan.tx_byte  = out_rsp_ff.tx_byte;
   assign rsp_chan.rx_valid = out_rsp_ff.rx_valid;
   assign rsp_chan.rx_byte  = out_rsp_ff.rx_byte;
   assign rsp_chan.rx_index = out_rsp_ff.rx_index;
   assign rsp_chan.done_res = out_rsp_ff.done_res;
   assign rsp_chan.failed   = out_rsp_ff.failed;

endmodule : i2c_master_transaction_fsm
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the i2c master transaction sequencer against a cycle-free predictor
// of its command sequencing. Directed transactions cover address and length
// extremes, masking of status codes, every operation and the corner cases.
// Random write and read transactions with stray items follow under several
// idle and stall mixes, plus one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import i2cm_pkg::*;

   localparam int BUF_DEPTH = DEFAULT_MAX_BYTES;

   // one request transaction as the testbench builds it
   typedef struct {
      op_type             op;
      logic [ADDR7_W-1:0] addr;
      logic [LEN_W-1:0]   len;
      logic [7:0]         code;
      logic [BYTE_W-1:0]  rx;
      logic [BYTE_W-1:0]  wbyte;
   } bus_item_type;

   logic clock;
   logic reset;

   i2cm_req_if req_chan ();
   i2cm_rsp_if rsp_chan ();

   i2c_master_transaction_fsm dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // sequencer shadow state
   logic [7:0]        seq_addr_byte = '0;
   logic [LEN_W-1:0]  seq_total     = '0;
   logic [LEN_W-1:0]  seq_index     = '0;
   bit                seq_busy      = 1'b0;
   logic [7:0]        seq_wbuf [BUF_DEPTH];
   bit                seq_wbuf_known [BUF_DEPTH];

   rsp_type pending_rsps [$];
   rsp_type head_rsp;
   int      mismatch_count = 0;
   int      items_done     = 0;
   int      send_idle_pct  = 0;
   int      rsp_stall_pct  = 0;
   int      rsp_holdoff    = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

   // next ack or nack for a read, from the current byte index
   function automatic cmd_type read_reply();
      return (int'(seq_index) + 1 < int'(seq_total)) ? CMD_ACK : CMD_NACK;
   endfunction

   // expected response for one accepted transaction; updates shadow state
   function automatic rsp_type next_bus_response(input bus_item_type it, output bit counts);
      rsp_type    r;
      logic [7:0] code;
      int         n;
      bit         rd;
      r      = '0;
      counts = 1'b1;
      code   = it.code & STATUS_MASK;
      case (it.op)
         OP_LOAD: begin
            if (it.len < BUF_DEPTH) begin
               seq_wbuf[it.len]       = it.wbyte;
               seq_wbuf_known[it.len] = 1'b1;
            end else begin
               counts = 1'b0;
            end
         end
         OP_START_RD, OP_START_WR: begin
            rd = (it.op == OP_START_RD);
            n  = (it.len > BUF_DEPTH) ? BUF_DEPTH : int'(it.len);
            if (rd && n == 0) n = 1;
            seq_addr_byte = {it.addr, rd};
            seq_total     = n[LEN_W-1:0];
            seq_index     = '0;
            seq_busy      = 1'b1;
            r.command     = CMD_START;
         end
         default: begin
            if (!seq_busy) begin
               counts = 1'b0;
            end else begin
               case (code)
                  ST_START, ST_REP_START: begin
                     r.command = CMD_CONT;
                     r.tx_byte = seq_addr_byte;
                  end
                  ST_ARB_LOST: begin
                     r.done_res = 1'b1;
                     r.failed   = 1'b1;
                     seq_busy   = 1'b0;
                  end
                  ST_SLA_W_ACK, ST_DAT_W_ACK: begin
                     if (seq_index < seq_total && seq_index < BUF_DEPTH) begin
                        r.command = CMD_CONT;
                        r.tx_byte = seq_wbuf[seq_index];
                        seq_index = seq_index + 1'b1;
                     end else begin
                        r.command  = CMD_STOP;
                        r.done_res = 1'b1;
                        seq_busy   = 1'b0;
                     end
                  end
                  ST_SLA_W_NACK, ST_DAT_W_NACK, ST_SLA_R_NACK: begin
                     r.command  = CMD_STOP;
                     r.done_res = 1'b1;
                     r.failed   = 1'b1;
                     seq_busy   = 1'b0;
                  end
                  ST_SLA_R_ACK: r.command = read_reply();
                  ST_DAT_R_ACK, ST_DAT_R_NACK: begin
                     // bytes past the length are dropped
                     if (seq_index < seq_total) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = it.rx;
                        r.rx_index = seq_index[RX_INDEX_W-1:0];
                        seq_index  = seq_index + 1'b1;
                     end
                     if (code == ST_DAT_R_ACK) begin
                        r.command = read_reply();
                     end else begin
                        r.command  = CMD_STOP;
                        r.done_res = 1'b1;
                        seq_busy   = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
      endcase
      return r;
   endfunction

   function automatic bus_item_type make_item(input op_type op, input int unsigned addr,
                                              input int unsigned len, input int unsigned code,
                                              input int unsigned rx, input int unsigned wb);
      bus_item_type it;
      it.op    = op;
      it.addr  = addr[ADDR7_W-1:0];
      it.len   = len[LEN_W-1:0];
      it.code  = code[7:0];
      it.rx    = rx[7:0];
      it.wbyte = wb[7:0];
      return it;
   endfunction

   function automatic bus_item_type random_item();
      return make_item(op_type'($urandom_range(3)), $urandom_range(127), $urandom_range(31),
                       $urandom_range(255), $urandom_range(255), $urandom_range(255));
   endfunction

   // drive one transaction and record its expected response at acceptance
   task automatic send_item(input bus_item_type it);
      rsp_type exp_rsp;
      bit      counts;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= it.op;
      req_chan.slave_address <= it.addr;
      req_chan.length        <= it.len;
      req_chan.status_code   <= it.code;
      req_chan.bus_rx_byte   <= it.rx;
      req_chan.write_byte    <= it.wbyte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      exp_rsp = next_bus_response(it, counts);
      pending_rsps.push_back(exp_rsp);
      if (counts) items_done++;
   endtask

   // bus status event with random don't-care low bits, now and then after a stray item
   task automatic send_event(input int unsigned code);
      if ($urandom_range(24) == 0) send_item(random_item());
      send_item(make_item(OP_EVENT, $urandom_range(127), $urandom_range(31),
                          code | $urandom_range(7), $urandom_range(255), $urandom_range(255)));
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain_responses();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // response ready, with random stalls and an optional long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff > 0) begin
            rsp_holdoff--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, got_val);
         mismatch_count++;
      end
   endtask

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none actual command %0h",
                     $time, rsp_chan.command);
            mismatch_count++;
         end else begin
            head_rsp = pending_rsps.pop_front();
            check_field("command", 8'(head_rsp.command), 8'(rsp_chan.command));
            check_field("tx_byte", head_rsp.tx_byte, rsp_chan.tx_byte);
            check_field("rx_valid", 8'(head_rsp.rx_valid), 8'(rsp_chan.rx_valid));
            check_field("rx_byte", head_rsp.rx_byte, rsp_chan.rx_byte);
            check_field("rx_index", 8'(head_rsp.rx_index), 8'(rsp_chan.rx_index));
            check_field("done_res", 8'(head_rsp.done_res), 8'(rsp_chan.done_res));
            check_field("failed", 8'(head_rsp.failed), 8'(rsp_chan.failed));
         end
      end
   end

   // random write transaction, occasionally aborted
   task automatic random_write_txn();
      int n;
      int eff;
      n   = ($urandom_range(7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      eff = (n > BUF_DEPTH) ? BUF_DEPTH : n;
      send_item(make_item(OP_START_WR, $urandom_range(127), n, $urandom_range(255),
                          $urandom_range(255), $urandom_range(255)));
      send_event($urandom_range(1) ? ST_START : ST_REP_START);
      if ($urandom_range(19) == 0) begin
         send_event($urandom_range(1) ? ST_SLA_W_NACK : ST_ARB_LOST);
         return;
      end
      send_event(ST_SLA_W_ACK);
      // the last data ack past the length brings the stop
      repeat (eff) begin
         if ($urandom_range(39) == 0) begin
            send_event(ST_DAT_W_NACK);
            return;
         end
         send_event(ST_DAT_W_ACK);
      end
   endtask

   // random read transaction, sometimes running past its length
   task automatic random_read_txn();
      int n;
      int eff;
      int extra;
      n   = ($urandom_range(7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
      eff = (n > BUF_DEPTH) ? BUF_DEPTH : n;
      if (eff == 0) eff = 1;
      send_item(make_item(OP_START_RD, $urandom_range(127), n, $urandom_range(255),
                          $urandom_range(255), $urandom_range(255)));
      send_event($urandom_range(1) ? ST_START : ST_REP_START);
      if ($urandom_range(19) == 0) begin
         send_event($urandom_range(1) ? ST_SLA_R_NACK : ST_ARB_LOST);
         return;
      end
      send_event(ST_SLA_R_ACK);
      extra = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
      repeat (eff - 1 + extra) send_event(ST_DAT_R_ACK);
      send_event(ST_DAT_R_NACK);
   endtask

   // mostly well-formed transactions, the rest noise
   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
      int target;
      int pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target        = items_done + n_items;
      // every buffer entry gets a value before random events may read it
      for (int i = 0; i < BUF_DEPTH; i++) begin
         if (!seq_wbuf_known[i])
            send_item(make_item(OP_LOAD, $urandom_range(127), i, $urandom_range(255),
                                $urandom_range(255), $urandom_range(255)));
      end
      while (items_done < target) begin
         pick = $urandom_range(99);
         if (pick < 45) random_write_txn();
         else if (pick < 85) random_read_txn();
         else repeat ($urandom_range(1, 4)) send_item(random_item());
      end
   endtask

   task automatic test_buffer_loads();
      send_item(make_item(OP_LOAD, 0, 0, 0, 0, 8'h00));
      send_item(make_item(OP_LOAD, 127, 1, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(OP_LOAD, 0, 15, 0, 0, 8'hA5));
      // indexes past the buffer are dropped
      send_item(make_item(OP_LOAD, 0, 16, 0, 0, 8'h5A));
      send_item(make_item(OP_LOAD, 0, 31, 0, 0, 8'hC3));
   endtask

   task automatic test_write_sequence();
      send_item(make_item(OP_START_WR, 127, 2, 0, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_START | 8'h07, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_SLA_W_ACK, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_W_ACK, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_W_ACK | 8'h07, 0, 0));
   endtask

   task automatic test_read_sequence();
      // zero length read still moves one byte
      send_item(make_item(OP_START_RD, 0, 0, 0, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_REP_START, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_SLA_R_ACK, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_R_NACK, 8'hFF, 0));
   endtask

   task automatic test_corner_cases();
      // event while idle
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_R_ACK, 8'h77, 0));
      // start while busy, length saturation
      send_item(make_item(OP_START_WR, 8'h2A, 1, 0, 0, 0));
      send_item(make_item(OP_START_RD, 8'h55, 31, 0, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_SLA_R_ACK, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_R_ACK, 8'h00, 0));
      // unknown status codes
      send_item(make_item(OP_EVENT, 0, 0, 8'h00, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, 8'hF8, 0, 0));
      // arbitration lost
      send_item(make_item(OP_EVENT, 0, 0, ST_ARB_LOST, 0, 0));
      // read bytes beyond the length, then address nack
      send_item(make_item(OP_START_RD, 1, 1, 0, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_R_ACK, 8'h3C, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_DAT_R_ACK, 8'hC3, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_SLA_R_NACK, 0, 0));
      // empty write stops on the address ack
      send_item(make_item(OP_START_WR, 5, 0, 0, 0, 0));
      send_item(make_item(OP_EVENT, 0, 0, ST_SLA_W_ACK, 0, 0));
   endtask

   // response side held off while the sender keeps offering
   task automatic test_backpressure();
      int target;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      target        = items_done + 40;
      rsp_holdoff   = 300;
      while (items_done < target) begin
         if ($urandom_range(1)) random_read_txn();
         else random_write_txn();
      end
      drain_responses();
   endtask

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.operation     = '0;
      req_chan.slave_address = '0;
      req_chan.length        = '0;
      req_chan.status_code   = '0;
      req_chan.bus_rx_byte   = '0;
      req_chan.write_byte    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_buffer_loads();
      test_write_sequence();
      test_read_sequence();
      test_corner_cases();
      run_random_phase(0, 0, 420);
      test_backpressure();
      run_random_phase(51, 0, 400);
      run_random_phase(0, 51, 400);
      run_random_phase(23, 23, 400);

      drain_responses();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule : testbench

// File: files.f
hdl/i2cm_pkg.sv
hdl/i2cm_req_if.sv
hdl/i2cm_ram.sv
hdl/i2c_master_transaction_fsm.sv
tb/testbench.sv
